@@ sv/j1939_frame_signal_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef J1939_FRAME_SIGNAL_DECODER_ASSERT_SVH
`define J1939_FRAME_SIGNAL_DECODER_ASSERT_SVH

// Check a same-cycle implication.
`define JFSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication.
`define JFSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jfsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jfsd_pkg;

  // Item opcodes
  localparam logic [1:0] OP_DECODE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_VALUE     = 2'd0;
  localparam logic [1:0] ST_NOT_J1939 = 2'd1;
  localparam logic [1:0] ST_NO_DEF    = 2'd2;

  localparam logic [7:0] PF_PDU2_MIN = 8'd240;
  localparam logic [7:0] BCAST_ADDR  = 8'hFF;
  localparam logic [5:0] MAX_LEN     = 6'd32;
  localparam logic [3:0] MAX_DLC     = 4'd8;

  localparam int PGN_W   = 18;
  localparam int VALUE_W = 57;

  // One signal definition, as stored in the entry memory
  typedef struct packed {
    logic signed [15:0] bias;
    logic [23:0]        scale;
    logic [5:0]         bit_count;
    logic [2:0]         bit_start;
    logic [2:0]         byte_start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ sv/jfsd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jfsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/jfsd_value.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-stage value unit: extract field, multiply by resolution, add offset.
module jfsd_value
  import jfsd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [63:0]               data,
  input  wire logic [3:0]                dlc,
  input  wire entry_t                    ent,
  output logic                           done,
  output logic signed [VALUE_W-1:0]      value
);

  logic [63:0]        win64;
  logic [39:0]        win40;
  logic [31:0]        len_mask;
  logic [31:0]        raw;
  logic               zero;

  logic               v1_r, v2_r, done_r;
  logic [31:0]        raw_r;
  logic [23:0]        scale_r;
  logic signed [15:0] bias1_r, bias2_r;
  logic               zero1_r, zero2_r;
  logic [55:0]        prod_r;
  logic signed [VALUE_W-1:0] value_r;

  always_comb begin
    zero     = ({1'b0, ent.byte_start} >= dlc) || (ent.bit_count > MAX_LEN);
    win64    = data >> {ent.byte_start, 3'b000};
    win40    = win64[39:0] >> ent.bit_start;
    len_mask = (ent.bit_count == 6'd0) ? 32'h0 :
               (32'hFFFF_FFFF >> (MAX_LEN - ent.bit_count));
    raw      = zero ? 32'h0 : (win40[31:0] & len_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    raw_r   <= raw;
    scale_r <= ent.scale;
    bias1_r <= ent.bias;
    zero1_r <= zero;
    prod_r  <= raw_r * scale_r;
    bias2_r <= bias1_r;
    zero2_r <= zero1_r;
    // add the offset in Q.16 unless the field starts past the payload or is too long
    value_r <= zero2_r ? '0 :
               $signed({1'b0, prod_r}) + $signed({{25{bias2_r[15]}}, bias2_r, 16'h0000});
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

`default_nettype wire

@@ sv/j1939_frame_signal_decoder.sv @@
// Channel  | Handshake             | Payload
// -------- | --------------------- | ---------------------------------------------
// in_      | in_valid / in_stall   | opcode, frame, table entry fields
// out_     | out_valid / out_stall | status, header fields, slot_hit, value, last
//
// Flow: a write or clear beat leaves the block idle; a standard-ID frame goes
// straight to the final beat. An extended frame walks the tag memory one entry
// per cycle, pausing at each matching entry for the value pipeline and the
// re-read of the next entry; the single read port of the tag memory sets the
// walk rate.
// Reset: synchronous, active low; clears every entry's valid bit at once, so no
// clearing pass is needed. Entry fields hold no reset value.
// Stalls: out_stall holds the output register and pauses the walk when a
// second result is ready; in_stall is high from a decode beat until its last
// result is in the output register.
`timescale 1ns / 1ps
`default_nettype none

module j1939_frame_signal_decoder
  import jfsd_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [28:0]               in_can_id,
  input  wire logic                      in_is_extended,
  input  wire logic [3:0]                in_frame_dlc,
  input  wire logic [63:0]               in_frame_data,
  input  wire logic [5:0]                in_slot_index,
  input  wire logic [17:0]               in_slot_pgn,
  input  wire logic [2:0]                in_byte_start,
  input  wire logic [2:0]                in_bit_start,
  input  wire logic [5:0]                in_bit_count,
  input  wire logic [23:0]               in_scale_q16,
  input  wire logic signed [15:0]        in_bias,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_status,
  output logic [17:0]                    out_pgn,
  output logic [2:0]                     out_priority_res,
  output logic [7:0]                     out_source_addr,
  output logic [7:0]                     out_dest_addr,
  output logic [7:0]                     out_group_ext,
  output logic                           out_is_pdu1,
  output logic [5:0]                     out_slot_hit,
  output logic signed [VALUE_W-1:0]      out_signal_value,
  output logic                           out_last
);

  `include "j1939_frame_signal_decoder_assert.svh"

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_GO, S_CALC, S_PUSH, S_FIN
  } state_t;

  state_t state_r;

  // walk control
  logic [CW-1:0]          addr_r;
  logic                   cmp_vld_r;
  logic [IW-1:0]          cmp_idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   noj_r;

  // frame header and payload, held for the whole walk
  logic [63:0]            data_r;
  logic [3:0]             dlc_r;
  logic [PGN_W-1:0]       pgn_r;
  logic [2:0]             prio_r;
  logic [7:0]             sa_r;
  logic [7:0]             da_r;
  logic [7:0]             ge_r;
  logic                   pdu1_r;

  // matched entry and result staging
  entry_t                 ent_r;
  logic [IW-1:0]          hit_r;
  logic signed [VALUE_W-1:0] new_val_r;
  logic                   pend_vld_r;
  logic [IW-1:0]          pend_slot_r;
  logic signed [VALUE_W-1:0] pend_val_r;

  // output register
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [PGN_W-1:0]       out_pgn_r;
  logic [2:0]             out_prio_r;
  logic [7:0]             out_sa_r;
  logic [7:0]             out_da_r;
  logic [7:0]             out_ge_r;
  logic                   out_pdu1_r;
  logic [IW-1:0]          out_slot_r;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                   out_last_r;

  // combinational
  logic                   in_acc;
  logic                   slot_ok;
  logic                   wr_en;
  logic [IW-1:0]          wr_idx;
  logic                   rd_en;
  logic                   addr_lt;
  logic                   match;
  logic                   out_free;
  logic                   out_load;
  logic [PGN_W-1:0]       tag_rdata;
  logic [ENTRY_W-1:0]     ent_rdata;
  entry_t                 ent_wdata;
  logic [3:0]             dlc_eff;
  logic [63:0]            data_m;
  logic [7:0]             id_pf;
  logic [7:0]             id_ps;
  logic                   id_pdu1;
  logic                   val_done;
  logic signed [VALUE_W-1:0] val_value;

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    in_acc    = in_valid && !in_stall;
    slot_ok   = (int'(in_slot_index) < TABLE_DEPTH);
    wr_idx    = in_slot_index[IW-1:0];
    wr_en     = in_acc && (in_opcode == OP_WRITE) && slot_ok;
    addr_lt   = (int'(addr_r) < TABLE_DEPTH);
    rd_en     = (state_r == S_WALK) && addr_lt;
    match     = (state_r == S_WALK) && cmp_vld_r && valid_r[cmp_idx_r] &&
                (tag_rdata == pgn_r);
    out_free  = !out_valid_r || !out_stall;
    out_load  = ((state_r == S_PUSH) && pend_vld_r && out_free) ||
                ((state_r == S_FIN) && out_free);

    ent_wdata.bias       = in_bias;
    ent_wdata.scale      = in_scale_q16;
    ent_wdata.bit_count  = in_bit_count;
    ent_wdata.bit_start  = in_bit_start;
    ent_wdata.byte_start = in_byte_start;

    // clamp DLC and zero the bytes beyond it once, at accept
    dlc_eff = (in_frame_dlc > MAX_DLC) ? MAX_DLC : in_frame_dlc;
    for (int k = 0; k < 8; k++) begin
      data_m[8*k +: 8] = (k < int'(dlc_eff)) ? in_frame_data[8*k +: 8] : 8'h00;
    end

    id_pf   = in_can_id[23:16];
    id_ps   = in_can_id[15:8];
    id_pdu1 = (id_pf < PF_PDU2_MIN);
  end

  // tag memory: PGN per entry; valid bits live in valid_r
  jfsd_ram #(
    .WIDTH (PGN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (in_slot_pgn),
    .re    (rd_en),
    .raddr (addr_r[IW-1:0]),
    .rdata (tag_rdata)
  );

  // entry memory: field position, resolution and offset
  jfsd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (ent_wdata),
    .re    (rd_en),
    .raddr (addr_r[IW-1:0]),
    .rdata (ent_rdata)
  );

  jfsd_value u_value (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (state_r == S_GO),
    .data  (data_r),
    .dlc   (dlc_r),
    .ent   (ent_r),
    .done  (val_done),
    .value (val_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      noj_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // raise valid on a load, drop the output beat once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_opcode)
              OP_DECODE: begin
                data_r     <= data_m;
                dlc_r      <= dlc_eff;
                prio_r     <= in_can_id[28:26];
                sa_r       <= in_can_id[7:0];
                pdu1_r     <= id_pdu1;
                pgn_r      <= {in_can_id[25:24], id_pf, (id_pdu1 ? id_ps : 8'h00)};
                da_r       <= id_pdu1 ? id_ps : BCAST_ADDR;
                ge_r       <= id_pdu1 ? 8'h00 : id_ps;
                pend_vld_r <= 1'b0;
                addr_r     <= '0;
                cmp_vld_r  <= 1'b0;
                noj_r      <= !in_is_extended;
                state_r    <= in_is_extended ? S_WALK : S_FIN;
              end
              OP_WRITE: begin
                if (slot_ok) begin
                  valid_r[wr_idx] <= 1'b1;
                end
              end
              OP_CLEAR: begin
                if (slot_ok) begin
                  valid_r[wr_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_WALK: begin
          if (match) begin
            // hold the entry, rewind the read address past it
            ent_r     <= entry_t'(ent_rdata);
            hit_r     <= cmp_idx_r;
            addr_r    <= CW'(cmp_idx_r) + CW'(1);
            cmp_vld_r <= 1'b0;
            state_r   <= S_GO;
          end else if (addr_lt) begin
            addr_r    <= addr_r + CW'(1);
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= addr_r[IW-1:0];
          end else begin
            cmp_vld_r <= 1'b0;
            if (!cmp_vld_r) begin
              state_r <= S_FIN;
            end
          end
        end

        S_GO: begin
          state_r <= S_CALC;
        end

        S_CALC: begin
          if (val_done) begin
            new_val_r <= val_value;
            state_r   <= S_PUSH;
          end
        end

        S_PUSH: begin
          // a newer match proves the pending result is not the last one
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_status_r <= ST_VALUE;
              out_pgn_r    <= pgn_r;
              out_prio_r   <= prio_r;
              out_sa_r     <= sa_r;
              out_da_r     <= da_r;
              out_ge_r     <= ge_r;
              out_pdu1_r   <= pdu1_r;
              out_slot_r   <= pend_slot_r;
              out_val_r    <= pend_val_r;
              out_last_r   <= 1'b0;
            end
            pend_vld_r  <= 1'b1;
            pend_slot_r <= hit_r;
            pend_val_r  <= new_val_r;
            state_r     <= S_WALK;
          end
        end

        S_FIN: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            if (noj_r) begin
              out_status_r <= ST_NOT_J1939;
              out_pgn_r    <= '0;
              out_prio_r   <= '0;
              out_sa_r     <= '0;
              out_da_r     <= '0;
              out_ge_r     <= '0;
              out_pdu1_r   <= 1'b0;
              out_slot_r   <= '0;
              out_val_r    <= '0;
            end else begin
              out_status_r <= pend_vld_r ? ST_VALUE : ST_NO_DEF;
              out_pgn_r    <= pgn_r;
              out_prio_r   <= prio_r;
              out_sa_r     <= sa_r;
              out_da_r     <= da_r;
              out_ge_r     <= ge_r;
              out_pdu1_r   <= pdu1_r;
              out_slot_r   <= pend_vld_r ? pend_slot_r : '0;
              out_val_r    <= pend_vld_r ? pend_val_r : '0;
            end
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_pgn          = out_pgn_r;
  assign out_priority_res = out_prio_r;
  assign out_source_addr  = out_sa_r;
  assign out_dest_addr    = out_da_r;
  assign out_group_ext    = out_ge_r;
  assign out_is_pdu1      = out_pdu1_r;
  assign out_slot_hit     = 6'(out_slot_r);
  assign out_signal_value = out_val_r;
  assign out_last         = out_last_r;

  `JFSD_ASSERT_IMP(a_no_overwrite, out_load && out_valid_r, !out_stall,
                   "output beat overwritten while stalled")
  `JFSD_ASSERT_IMP(a_done_in_calc, val_done, state_r == S_CALC,
                   "value unit finished outside the calc state")
  `JFSD_ASSERT_IMP(a_addr_bound, state_r == S_WALK, int'(addr_r) <= TABLE_DEPTH,
                   "walk address past table depth")
  `JFSD_ASSERT_IMP(a_noj_no_pend, (state_r == S_FIN) && noj_r, !pend_vld_r,
                   "pending value on a standard-ID frame")
  `JFSD_ASSERT_NXT(a_fin_to_idle, (state_r == S_FIN) && out_free,
                   out_valid_r && out_last_r && (state_r == S_IDLE),
                   "final beat not loaded on leaving the walk")

endmodule

`default_nettype wire

@@ tb/j1939_frame_signal_decoder_tb.sv @@
`timescale 1ns / 1ps

module j1939_frame_signal_decoder_tb;
  import jfsd_pkg::*;

  localparam int TABLE_DEPTH = 64;
  // Opcode 3 is reserved: the block must swallow the beat without a result.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Cycles to let the walk finish after the last expected result.
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int DRAIN_LIMIT = 200000;

  // One input beat, every field at its port width.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [28:0]        can_id;
    logic               is_extended;
    logic [3:0]         frame_dlc;
    logic [63:0]        frame_data;
    logic [5:0]         slot_index;
    logic [17:0]        slot_pgn;
    logic [2:0]         byte_start;
    logic [2:0]         bit_start;
    logic [5:0]         bit_count;
    logic [23:0]        scale_q16;
    logic signed [15:0] bias;
  } frame_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] pgn;
    logic [2:0]  priority_res;
    logic [7:0]  source_addr;
    logic [7:0]  dest_addr;
    logic [7:0]  group_ext;
    logic        is_pdu1;
    logic [5:0]  slot_hit;
    logic [56:0] signal_value;
    logic        last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_opcode = OP_DECODE;
  logic [28:0]               in_can_id = '0;
  logic                      in_is_extended = 1'b0;
  logic [3:0]                in_frame_dlc = '0;
  logic [63:0]               in_frame_data = '0;
  logic [5:0]                in_slot_index = '0;
  logic [17:0]               in_slot_pgn = '0;
  logic [2:0]                in_byte_start = '0;
  logic [2:0]                in_bit_start = '0;
  logic [5:0]                in_bit_count = '0;
  logic [23:0]               in_scale_q16 = '0;
  logic signed [15:0]        in_bias = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_status;
  logic [17:0]               out_pgn;
  logic [2:0]                out_priority_res;
  logic [7:0]                out_source_addr;
  logic [7:0]                out_dest_addr;
  logic [7:0]                out_group_ext;
  logic                      out_is_pdu1;
  logic [5:0]                out_slot_hit;
  logic signed [VALUE_W-1:0] out_signal_value;
  logic                      out_last;

  // Idle rates in percent for the sender and for the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;

  // Long receiver hold-off, counted out by its own process below.
  event hold_start;
  int   hold_cycles = 0;
  logic hold_off = 1'b0;

  // Shadow copy of the signal table.
  bit          tbl_valid [TABLE_DEPTH];
  logic [17:0] tbl_pgn   [TABLE_DEPTH];
  entry_t      tbl_def   [TABLE_DEPTH];

  // Results predicted but not yet seen, oldest first.
  frame_result_t pending_results[$];
  // Identifiers whose PGNs the random traffic loads into the table.
  logic [28:0] pgn_pool[$];

  j1939_frame_signal_decoder #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_can_id        (in_can_id),
    .in_is_extended   (in_is_extended),
    .in_frame_dlc     (in_frame_dlc),
    .in_frame_data    (in_frame_data),
    .in_slot_index    (in_slot_index),
    .in_slot_pgn      (in_slot_pgn),
    .in_byte_start    (in_byte_start),
    .in_bit_start     (in_bit_start),
    .in_bit_count     (in_bit_count),
    .in_scale_q16     (in_scale_q16),
    .in_bias          (in_bias),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_pgn          (out_pgn),
    .out_priority_res (out_priority_res),
    .out_source_addr  (out_source_addr),
    .out_dest_addr    (out_dest_addr),
    .out_group_ext    (out_group_ext),
    .out_is_pdu1      (out_is_pdu1),
    .out_slot_hit     (out_slot_hit),
    .out_signal_value (out_signal_value),
    .out_last         (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Split an extended identifier into the header fields of a result.
  function automatic frame_result_t frame_header(logic [28:0] id);
    frame_result_t r;
    logic [7:0] pf;
    logic [7:0] ps;
    r = '0;
    pf = id[23:16];
    ps = id[15:8];
    r.priority_res = id[28:26];
    r.source_addr = id[7:0];
    r.is_pdu1 = (pf < PF_PDU2_MIN);
    // PDU1 keeps PS as destination and in the PGN; PDU2 broadcasts and
    // carries PS as group extension.
    r.pgn = {id[25:24], pf, r.is_pdu1 ? ps : 8'h00};
    r.dest_addr = r.is_pdu1 ? ps : BCAST_ADDR;
    r.group_ext = r.is_pdu1 ? 8'h00 : ps;
    return r;
  endfunction

  // PGN of an extended identifier.
  function automatic logic [17:0] pgn_of(logic [28:0] id);
    frame_result_t r;
    r = frame_header(id);
    return r.pgn;
  endfunction

  // Little-endian bit field times the Q8.16 resolution plus the offset.
  function automatic logic [56:0] scaled_signal(logic [63:0] data, logic [3:0] dlc,
                                                entry_t def);
    logic [3:0]  n_bytes;
    logic [39:0] window;
    logic [39:0] shifted;
    logic [31:0] mask;
    logic [31:0] raw;
    logic [63:0] prod;
    logic [63:0] offset;
    int          k;
    n_bytes = (dlc > MAX_DLC) ? MAX_DLC : dlc;
    // A field starting past the payload, or too long, reads as zero outright.
    if (def.byte_start >= n_bytes || def.bit_count > MAX_LEN) return '0;
    window = '0;
    // Gather up to five bytes so a 32-bit field at any bit offset fits.
    for (int i = 0; i < 5; i++) begin
      k = def.byte_start + i;
      if (k < n_bytes) window[8*i +: 8] = data[8*k +: 8];
    end
    mask = (def.bit_count >= MAX_LEN) ? 32'hFFFF_FFFF : 32'((64'd1 << def.bit_count) - 1);
    shifted = window >> def.bit_start;
    raw = shifted[31:0] & mask;
    prod = 64'(raw) * 64'(def.scale);
    offset = {{32{def.bias[15]}}, def.bias, 16'h0000};
    return 57'(prod + offset);
  endfunction

  // Walk the shadow table for one decode beat and queue the results.
  function automatic void decode_signals(frame_beat_t b);
    frame_result_t hdr;
    frame_result_t prev;
    bit            have_prev;
    have_prev = 1'b0;
    if (!b.is_extended) begin
      prev = '0;
      prev.status = ST_NOT_J1939;
      prev.last = 1'b1;
      pending_results.push_back(prev);
      return;
    end
    hdr = frame_header(b.can_id);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_pgn[i] == hdr.pgn) begin
        // Hold each hit back one step so the final one can carry last.
        if (have_prev) pending_results.push_back(prev);
        prev = hdr;
        prev.status = ST_VALUE;
        prev.slot_hit = 6'(i);
        prev.signal_value = scaled_signal(b.frame_data, b.frame_dlc, tbl_def[i]);
        have_prev = 1'b1;
      end
    end
    if (!have_prev) begin
      prev = hdr;
      prev.status = ST_NO_DEF;
    end
    prev.last = 1'b1;
    pending_results.push_back(prev);
  endfunction

  // Update the shadow state for an accepted beat.
  function automatic void apply_beat(frame_beat_t b);
    entry_t def;
    case (b.opcode)
      OP_WRITE: begin
        def.bias = b.bias;
        def.scale = b.scale_q16;
        def.bit_count = b.bit_count;
        def.bit_start = b.bit_start;
        def.byte_start = b.byte_start;
        tbl_valid[b.slot_index] = 1'b1;
        tbl_pgn[b.slot_index] = b.slot_pgn;
        tbl_def[b.slot_index] = def;
      end
      OP_CLEAR: tbl_valid[b.slot_index] = 1'b0;
      OP_DECODE: decode_signals(b);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Every field random; callers override what the beat is about.
  function automatic frame_beat_t random_beat();
    frame_beat_t b;
    b.opcode = 2'($urandom_range(3));
    b.can_id = 29'($urandom);
    b.is_extended = 1'($urandom_range(1));
    b.frame_dlc = 4'($urandom_range(15));
    b.frame_data = {$urandom, $urandom};
    b.slot_index = 6'($urandom_range(TABLE_DEPTH - 1));
    b.slot_pgn = 18'($urandom);
    b.byte_start = 3'($urandom);
    b.bit_start = 3'($urandom);
    b.bit_count = 6'($urandom);
    b.scale_q16 = 24'($urandom);
    b.bias = 16'($urandom);
    return b;
  endfunction

  // Drive one beat and hold it until accepted; idle first at the sender rate.
  task automatic send_beat(input frame_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= b.opcode;
    in_can_id      <= b.can_id;
    in_is_extended <= b.is_extended;
    in_frame_dlc   <= b.frame_dlc;
    in_frame_data  <= b.frame_data;
    in_slot_index  <= b.slot_index;
    in_slot_pgn    <= b.slot_pgn;
    in_byte_start  <= b.byte_start;
    in_bit_start   <= b.bit_start;
    in_bit_count   <= b.bit_count;
    in_scale_q16   <= b.scale_q16;
    in_bias        <= b.bias;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(b);
  endtask

  // Drop valid after a burst so the last beat is not taken twice.
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_entry(input logic [5:0] slot, input logic [17:0] pgn,
                             input logic [2:0] byte_pos, input logic [2:0] bit_pos,
                             input logic [5:0] len, input logic [23:0] scale,
                             input logic signed [15:0] bias);
    frame_beat_t b;
    b = random_beat();
    b.opcode = OP_WRITE;
    b.slot_index = slot;
    b.slot_pgn = pgn;
    b.byte_start = byte_pos;
    b.bit_start = bit_pos;
    b.bit_count = len;
    b.scale_q16 = scale;
    b.bias = bias;
    send_beat(b);
  endtask

  task automatic decode_frame(input logic [28:0] id, input logic ext,
                              input logic [3:0] dlc, input logic [63:0] data);
    frame_beat_t b;
    b = random_beat();
    b.opcode = OP_DECODE;
    b.can_id = id;
    b.is_extended = ext;
    b.frame_dlc = dlc;
    b.frame_data = data;
    send_beat(b);
  endtask

  // Decode beat aimed at one of the loaded PGNs, with fresh priority, source
  // and, for PDU2, group extension.
  function automatic frame_beat_t pool_decode_beat();
    frame_beat_t b;
    logic [28:0] id;
    b = random_beat();
    id = pgn_pool[$urandom_range(pgn_pool.size() - 1)];
    id[28:26] = 3'($urandom);
    id[7:0] = 8'($urandom);
    if (id[23:16] >= PF_PDU2_MIN) id[15:8] = 8'($urandom);
    b.opcode = OP_DECODE;
    b.is_extended = 1'b1;
    b.can_id = id;
    if ($urandom_range(3) != 0) b.frame_dlc = MAX_DLC;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Standard identifiers never reach the table walk.
  task automatic test_standard_frames();
    decode_frame(29'h1FFF_FFFF, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    decode_frame(29'h000_0000, 1'b0, 4'd0, 64'h0);
    drop_valid();
  endtask

  // Empty table: every extended frame gets the no-definition beat. Cover the
  // PDU1/PDU2 boundary at PF 239 and 240.
  task automatic test_unmatched_pgn();
    decode_frame({3'd0, 2'b00, 8'hEF, 8'h20, 8'h30}, 1'b1, 4'd8, 64'h0123_4567_89AB_CDEF);
    decode_frame({3'd7, 2'b11, 8'hF0, 8'hFF, 8'h00}, 1'b1, 4'd8, 64'h0);
    decode_frame(29'h1FFF_FFFF, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    drop_valid();
  endtask

  // Field extremes on one PDU1 PGN, seen through several payload lengths.
  task automatic test_signal_extremes();
    logic [28:0] id;
    logic [17:0] pgn;
    id = {3'd6, 2'b00, 8'hEA, 8'h3F, 8'h17};
    pgn = pgn_of(id);
    // zero length: value is the offset alone
    write_entry(6'd0, pgn, 3'd0, 3'd0, 6'd0, 24'h01_0000, -16'sd32768);
    write_entry(6'd1, pgn, 3'd0, 3'd0, MAX_LEN, 24'hFF_FFFF, 16'sd32767);
    // starts at byte four, bit seven: runs past the end of the payload
    write_entry(6'd2, pgn, 3'd4, 3'd7, MAX_LEN, 24'h01_0000, 16'sd0);
    write_entry(6'd3, pgn, 3'd7, 3'd3, 6'd5, 24'h00_0001, 16'sd1);
    // one past and far past the length limit
    write_entry(6'd4, pgn, 3'd0, 3'd0, 6'd33, 24'h01_0000, 16'sd5);
    write_entry(6'd5, pgn, 3'd7, 3'd7, 6'd63, 24'hFF_FFFF, -16'sd1);
    write_entry(6'd63, pgn, 3'd3, 3'd5, 6'd17, 24'h12_3456, -16'sd1);
    decode_frame(id, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    // DLC above eight clamps to eight
    decode_frame(id, 1'b1, 4'd15, 64'hA5C3_0F96_5A3C_F069);
    // DLC zero: every start byte is past the payload
    decode_frame(id, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    // bytes at or past DLC read as zero
    decode_frame(id, 1'b1, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF);
    drop_valid();
  endtask

  // Clear, reserved opcode, a decode after both, and a PDU2 entry hit.
  task automatic test_table_maintenance();
    frame_beat_t b;
    logic [28:0] pdu2_id;
    b = random_beat();
    b.opcode = OP_CLEAR;
    b.slot_index = 6'd1;
    send_beat(b);
    // reserved opcode must not touch slot 1
    b = random_beat();
    b.opcode = OP_RESERVED;
    b.slot_index = 6'd1;
    b.slot_pgn = pgn_of({3'd6, 2'b00, 8'hEA, 8'h3F, 8'h17});
    send_beat(b);
    decode_frame({3'd2, 2'b00, 8'hEA, 8'h3F, 8'hFE}, 1'b1, 4'd8, 64'h8000_0001_7FFF_FFFE);
    pdu2_id = {3'd3, 2'b11, 8'hFE, 8'hA5, 8'h42};
    write_entry(6'd10, pgn_of(pdu2_id), 3'd1, 3'd2, 6'd12, 24'h00_8000, 16'sd100);
    decode_frame(pdu2_id, 1'b1, 4'd8, 64'h1122_3344_5566_7788);
    drop_valid();
  endtask

  // Mostly table writes and decodes that hit them; the rest is noise.
  task automatic test_random_traffic(input int n_beats);
    frame_beat_t b;
    logic [28:0] id;
    int          pick;
    while (pgn_pool.size() < 6) begin
      id = 29'($urandom);
      // half PDU2, half PDU1
      if (pgn_pool.size() % 2 == 1) id[23:16] = 8'($urandom_range(240, 255));
      else id[23:16] = 8'($urandom_range(0, 239));
      pgn_pool.push_back(id);
    end
    for (int i = 0; i < n_beats; i++) begin
      pick = $urandom_range(99);
      b = random_beat();
      if (pick < 52) begin
        b = pool_decode_beat();
      end else if (pick < 74) begin
        b.opcode = OP_WRITE;
        b.slot_pgn = pgn_of(pgn_pool[$urandom_range(pgn_pool.size() - 1)]);
        if ($urandom_range(3) != 0) b.bit_count = 6'($urandom_range(0, 32));
      end else if (pick < 80) begin
        b.opcode = OP_CLEAR;
      end else if (pick < 85) begin
        b.opcode = OP_WRITE;
      end else if (pick < 91) begin
        b.opcode = OP_DECODE;
        b.is_extended = 1'b1;
      end else if (pick < 96) begin
        b.opcode = OP_DECODE;
        b.is_extended = 1'b0;
      end else begin
        b.opcode = OP_RESERVED;
      end
      send_beat(b);
    end
    drop_valid();
  endtask

  // Hold the receiver off for a long stretch while decodes keep coming, so
  // the output backs up and in_stall rises.
  task automatic test_input_backpressure();
    hold_cycles = 500;
    -> hold_start;
    for (int i = 0; i < 8; i++) send_beat(pool_decode_beat());
    drop_valid();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checking
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(hold_start);
      hold_off <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Stall at the receiver rate, or solid while a hold-off runs.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, status %0d",
                                  out_status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(out_status), 64'(want.status));
        check_field("pgn", 64'(out_pgn), 64'(want.pgn));
        check_field("priority_res", 64'(out_priority_res), 64'(want.priority_res));
        check_field("source_addr", 64'(out_source_addr), 64'(want.source_addr));
        check_field("dest_addr", 64'(out_dest_addr), 64'(want.dest_addr));
        check_field("group_ext", 64'(out_group_ext), 64'(want.group_ext));
        check_field("is_pdu1", 64'(out_is_pdu1), 64'(want.is_pdu1));
        check_field("slot_hit", 64'(out_slot_hit), 64'(want.slot_hit));
        check_field("signal_value", {7'b0, out_signal_value}, {7'b0, want.signal_value});
        check_field("last", 64'(out_last), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 52;
    test_standard_frames();
    test_unmatched_pgn();
    test_signal_extremes();
    test_table_maintenance();
    test_random_traffic(130);

    send_idle_pct = 52;
    recv_idle_pct = 9;
    test_random_traffic(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_input_backpressure();
    test_random_traffic(130);

    // Wait out the remaining results, then give a late extra beat time to show.
    for (int c = 0; c < DRAIN_LIMIT && pending_results.size() != 0; c++) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("j1939_frame_signal_decoder_tb OK");
    end else begin
      $display("j1939_frame_signal_decoder_tb NOT OK");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(4_000_000);
    $display("j1939_frame_signal_decoder_tb NOT OK");
    $finish;
  end

endmodule

@@ j1939_frame_signal_decoder.f @@
+incdir+sv
sv/jfsd_pkg.sv
sv/jfsd_ram.sv
sv/jfsd_value.sv
sv/j1939_frame_signal_decoder.sv
tb/j1939_frame_signal_decoder_tb.sv
